>>> rtl/scc_pkg.sv
// Shared widths, constants and state type for the subset sum counter.
package scc_pkg;

  localparam int ELEM_W          = 16;
  localparam int TARGET_W        = 10;
  localparam int COUNT_W         = 30;
  localparam int MAX_SUM_DEFAULT = 1023;

  localparam logic [COUNT_W-1:0] COUNT_PRIME = 30'd1000000007;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH,
    ST_DONE
  } state_t;

endpackage

>>> rtl/scc_if.sv
// Valid/ready channel interfaces for element input and count output.
interface scc_in_if;
  import scc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element_value;
  logic              is_last;

  modport source (output valid, output element_value, output is_last, input ready);
  modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

interface scc_out_if;
  import scc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] subset_count;

  modport source (output valid, output subset_count, input ready);
  modport sink   (input valid, input subset_count, output ready);
endinterface

>>> rtl/scc_ram.sv
// Generic RAM: one write port, two registered read ports.
module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/subset_sum_count_mod.sv
// Subset sum counter, modulo 1000000007, over a streamed set of elements.
// Each item sweeps the count row from MAX_SUM down to 0, one entry per cycle
// through the row RAM (read, add mod prime, write back); a new item is taken
// only after the sweep is written back (and, after a last item, once out_chan
// has taken any earlier count), and the set's count is then put on out_chan.
// Reset leaves the row RAM untouched; a flag makes the row read as reset values.
module subset_sum_count_mod #(
  parameter int MAX_SUM = scc_pkg::MAX_SUM_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [scc_pkg::TARGET_W-1:0]  cfg_wdata,
  scc_in_if.sink                        in_chan,
  scc_out_if.source                     out_chan
);
  import scc_pkg::*;

  localparam int DEPTH = MAX_SUM + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CMP_W = 17;
  localparam logic [AW-1:0]     LAST_IDX = AW'(MAX_SUM);
  localparam logic [ELEM_W-1:0] MAX_ELEM = ELEM_W'(MAX_SUM);

  state_t state_r, state_nxt;

  logic [TARGET_W-1:0] target_r;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [ELEM_W-1:0]   x_r;
  logic                last_r, zero_r, inr_r, fresh_r;
  logic                b_valid_r, b_take_r, b_src0_r;
  logic [AW-1:0]       b_idx_r;
  logic [COUNT_W-1:0]  result_r, result_nxt;
  logic                out_valid_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic               in_fire, sweep_en, done_fire;
  logic [AW-1:0]      raddr_b;
  logic               take_a, src0_a;
  logic [COUNT_W-1:0] rd_a, rd_b, a_val, b_val, addend, new_val;
  logic [COUNT_W:0]   sum_w, red_w;

  scc_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_row (
    .clk     (clk),
    .we      (b_valid_r),
    .waddr   (b_idx_r),
    .wdata   (new_val),
    .raddr_a (idx_r),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_chan.valid) state_nxt = ST_SWEEP;
      ST_SWEEP: if (idx_r == '0) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!last_r || !out_valid_r || out_chan.ready) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_chan.ready = 1'b0;
    sweep_en      = 1'b0;
    done_fire     = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_chan.ready = 1'b1;
      ST_SWEEP: sweep_en = 1'b1;
      ST_FLUSH: ;
      ST_DONE:  done_fire = !last_r || !out_valid_r || out_chan.ready;
      default:  ;
    endcase
  end

  assign in_fire = in_chan.valid && in_chan.ready;

  // read stage
  assign raddr_b = idx_r - x_r[AW-1:0];
  assign take_a  = inr_r && !zero_r && (ELEM_W'(idx_r) >= x_r);
  assign src0_a  = (ELEM_W'(idx_r) == x_r);
  assign idx_nxt = in_fire ? LAST_IDX : (sweep_en ? idx_r - AW'(1) : idx_r);

  // update stage
  assign a_val   = fresh_r ? ((b_idx_r == '0) ? COUNT_W'(1) : '0) : rd_a;
  assign b_val   = fresh_r ? (b_src0_r ? COUNT_W'(1) : '0) : rd_b;
  assign addend  = zero_r ? a_val : (b_take_r ? b_val : '0);
  assign sum_w   = {1'b0, a_val} + {1'b0, addend};
  assign red_w   = sum_w - {1'b0, COUNT_PRIME};
  assign new_val = (sum_w >= {1'b0, COUNT_PRIME}) ? red_w[COUNT_W-1:0] : sum_w[COUNT_W-1:0];

  always_comb begin
    result_nxt = result_r;
    if (in_fire) begin
      result_nxt = '0;
    end else if (b_valid_r && (CMP_W'(b_idx_r) == CMP_W'(target_r))) begin
      result_nxt = new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      target_r    <= '0;
      fresh_r     <= 1'b1;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      b_valid_r <= sweep_en;
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      if (done_fire) begin
        fresh_r <= last_r;
      end
      if (done_fire && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    result_r <= result_nxt;
    b_idx_r  <= idx_r;
    b_take_r <= take_a;
    b_src0_r <= src0_a;
    if (in_fire) begin
      x_r    <= in_chan.element_value;
      last_r <= in_chan.is_last;
      zero_r <= (in_chan.element_value == '0);
      inr_r  <= (in_chan.element_value <= MAX_ELEM);
    end
    if (done_fire && last_r) begin
      out_count_r <= result_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.subset_count = out_count_r;

endmodule

>>> tb/subset_sum_count_mod_test.sv
// Testbench for subset_sum_count_mod: predicts the per-set subset counts and checks each result.
`timescale 1ns / 1ps

module subset_sum_count_mod_test;
  import scc_pkg::*;

  localparam int ROW_MAX     = MAX_SUM_DEFAULT;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE      = ROW_MAX + 16;

  class subset_counter;
    bit [COUNT_W-1:0]  row[ROW_MAX+1];
    bit [TARGET_W-1:0] target;
    bit [COUNT_W-1:0]  counts_due[$];
    int                mismatches;

    function new();
      target = '0;
      mismatches = 0;
      clear_row();
    endfunction

    function void clear_row();
      foreach (row[i]) row[i] = '0;
      row[0] = COUNT_W'(1);
    endfunction

    function bit [COUNT_W-1:0] add_mod(bit [COUNT_W-1:0] a, bit [COUNT_W-1:0] b);
      bit [COUNT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, COUNT_PRIME}) sum = sum - {1'b0, COUNT_PRIME};
      return sum[COUNT_W-1:0];
    endfunction

    function void take_element(bit [ELEM_W-1:0] value, bit last);
      int x;
      bit [COUNT_W-1:0] due;
      x = int'(value);
      if (x <= ROW_MAX) begin
        if (x == 0) begin
          foreach (row[s]) row[s] = add_mod(row[s], row[s]);
        end else begin
          for (int s = ROW_MAX; s >= x; s--) row[s] = add_mod(row[s], row[s-x]);
        end
      end
      if (last) begin
        due = '0;
        if (target <= ROW_MAX) due = row[target];
        counts_due = {counts_due, due};
        clear_row();
      end
    endfunction

    function void check_count(bit [COUNT_W-1:0] got);
      bit [COUNT_W-1:0] want;
      if (counts_due.size() == 0) begin
        $error("subset_count: unexpected result %0d", got);
        mismatches++;
      end else begin
        want = counts_due.pop_front();
        if (got !== want) begin
          $error("subset_count expected %0d actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TARGET_W-1:0] cfg_wdata;

  scc_in_if  in_chan ();
  scc_out_if out_chan ();

  subset_sum_count_mod dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  subset_counter counter = new();
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  long_gaps      = 0;
  int  cycles         = 0;
  int  set_left       = 0;
  bit  set_is_long    = 0;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) counter.check_count(out_chan.subset_count);
  end

  always @(negedge clk) begin
    out_chan.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // caller sits at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [ELEM_W-1:0] value, input logic last);
    if (long_gaps && $urandom_range(0, 99) < 10) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, ROW_MAX + 80)) @(negedge clk);
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid         = 1'b1;
    in_chan.element_value = value;
    in_chan.is_last       = last;
    do @(posedge clk); while (!in_chan.ready);
    counter.take_element(value, last);
    @(negedge clk);
  endtask

  // all counts in, then let any sweep still running finish
  task automatic wait_idle();
    in_chan.valid = 1'b0;
    while (counter.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_target(input logic [TARGET_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    counter.target = value;
  endtask

  function automatic logic [ELEM_W-1:0] pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (set_is_long) return ELEM_W'($urandom_range(0, 2));
    if (r < 35) return ELEM_W'($urandom_range(0, 3));
    if (r < 65) return ELEM_W'($urandom_range(0, 31));
    if (r < 82) return ELEM_W'($urandom_range(0, ROW_MAX));
    if (r < 92) return ELEM_W'($urandom_range(ROW_MAX + 1, 65535));
    return ELEM_W'($urandom_range(0, 65535));
  endfunction

  task automatic run_phase(input int mode, input int n_items);
    logic [TARGET_W-1:0] tgt;
    logic [ELEM_W-1:0]   value;
    case (mode % 4)
      0: tgt = TARGET_W'($urandom_range(0, 8));
      1: tgt = TARGET_W'($urandom_range(0, ROW_MAX));
      2: tgt = TARGET_W'(ROW_MAX);
      default: tgt = TARGET_W'($urandom_range(9, 60));
    endcase
    send_idle_pct  = (mode % 4 == 1) ? 88 : (mode % 4 == 3) ? 29 : 0;
    recv_stall_pct = (mode % 4 == 2) ? 88 : (mode % 4 == 3) ? 29 : 0;
    long_gaps      = (mode % 4 == 1) || (mode % 4 == 3);
    set_target(tgt);
    for (int i = 0; i < n_items; i++) begin
      if (set_left == 0) begin
        set_is_long = ($urandom_range(0, 99) < 12);
        set_left    = set_is_long ? $urandom_range(20, 45) : $urandom_range(1, 6);
      end
      value = pick_element();
      set_left--;
      send_item(value, set_left == 0);
    end
    wait_idle();
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_chan.valid         = 1'b0;
    in_chan.element_value = '0;
    in_chan.is_last       = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // target zero: empty subset, zero doubling, oversized element ignored
    set_target('0);
    send_item(16'd0, 1'b1);
    send_item(16'hFFFF, 1'b1);
    send_item(16'd1023, 1'b0);
    send_item(16'd0, 1'b1);
    send_item(16'd1, 1'b0);
    send_item(16'd1, 1'b1);
    send_item(16'd3, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b1);
    wait_idle();

    // top of the row
    set_target(TARGET_W'(ROW_MAX));
    send_item(16'd1023, 1'b1);
    send_item(16'd512, 1'b0);
    send_item(16'd511, 1'b0);
    send_item(16'd1023, 1'b1);
    send_item(16'd1024, 1'b1);
    send_item(16'h8000, 1'b0);
    send_item(16'd1, 1'b1);
    send_item(16'd5, 1'b0);
    wait_idle();

    // target changed while a set is open
    set_target(10'd12);
    send_item(16'd7, 1'b1);
    wait_idle();

    for (int p = 0; p < 8; p++) run_phase(p, 50);
    if (set_left != 0) begin
      while (set_left > 1) begin
        set_left--;
        send_item(pick_element(), 1'b0);
      end
      set_left = 0;
      send_item(pick_element(), 1'b1);
    end
    wait_idle();

    if (counter.mismatches == 0 && counter.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
